FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the DAG closure block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DCR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCR_ASSERT(lbl, clk, rstn, prop, msg)
`define DCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/dcr_pkg.sv
// Shared constants and types of the DAG closure and reduction block.
// Used by every module of the block but dcr_ram; depends on nothing.
package dcr_pkg;

    localparam int MASK_W        = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int STAT_W        = 2;
    localparam int MAX_TASKS_DEF = 64;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FWD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2,
        S_DONE
    } t_state;

    // Sequencer to datapath control.
    typedef struct packed {
        logic             load;
        logic             tbl_full;
        logic [CNT_W-1:0] task_no;
        logic             rd_v;
        logic [IDX_W-1:0] rd_idx;
        logic             pass2;
        logic             start2;
        logic             done;
    } t_ctl;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MASK_W-1:0] reduced;
        logic [MASK_W-1:0] full;
        logic [IDX_W-1:0]  tno;
        logic              last;
    } t_res;

endpackage

FILE: hdl/dcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dcr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/dcr_ctrl.sv
// Sequencer: task counter, the two read passes over the closure store and
// the row write-back. Depends on dcr_pkg.
module dcr_ctrl #(
    parameter int MAX_TASKS = dcr_pkg::MAX_TASKS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_last,
    input  logic                         i_out_free,
    output logic                         o_ready,
    output logic                         o_rd_en,
    output logic [$clog2(MAX_TASKS)-1:0] o_rd_addr,
    output logic                         o_wr_en,
    output logic [$clog2(MAX_TASKS)-1:0] o_wr_addr,
    output dcr_pkg::t_ctl                o_ctl
);

    localparam int AW = $clog2(MAX_TASKS);

    dcr_pkg::t_state r_state, n_state;

    logic [dcr_pkg::CNT_W-1:0] r_idx;
    logic [dcr_pkg::CNT_W-1:0] r_count;
    logic [dcr_pkg::CNT_W-1:0] r_task;
    logic                      r_rd_v;
    logic [dcr_pkg::IDX_W-1:0] r_rd_idx;

    logic accept;
    logic tbl_full;
    logic in_pass;
    logic rd_en;
    logic pass_end;

    // No item is taken while reset is held.
    assign accept   = i_valid && (r_state == dcr_pkg::S_IDLE) && i_rst_n;
    assign tbl_full = r_count >= dcr_pkg::CNT_W'(MAX_TASKS);
    assign in_pass  = (r_state == dcr_pkg::S_PASS1) || (r_state == dcr_pkg::S_PASS2);
    assign rd_en    = in_pass && (r_idx < r_task);
    // A pass is over once every address is issued and the last row is consumed.
    assign pass_end = in_pass && !rd_en && !r_rd_v;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dcr_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = tbl_full ? dcr_pkg::S_DONE : dcr_pkg::S_PASS1;
                end
            end
            dcr_pkg::S_PASS1: begin
                if (pass_end) begin
                    n_state = dcr_pkg::S_PASS2;
                end
            end
            dcr_pkg::S_PASS2: begin
                if (pass_end) begin
                    n_state = dcr_pkg::S_DONE;
                end
            end
            dcr_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = dcr_pkg::S_IDLE;
                end
            end
            default: n_state = dcr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready         = (r_state == dcr_pkg::S_IDLE) && i_rst_n;
        o_rd_en         = rd_en;
        o_rd_addr       = r_idx[AW-1:0];
        o_wr_en         = (r_state == dcr_pkg::S_PASS2) && pass_end;
        o_wr_addr       = r_task[AW-1:0];
        o_ctl.load      = accept;
        o_ctl.tbl_full  = tbl_full;
        o_ctl.task_no   = r_count;
        o_ctl.rd_v      = r_rd_v;
        o_ctl.rd_idx    = r_rd_idx;
        o_ctl.pass2     = (r_state == dcr_pkg::S_PASS2);
        o_ctl.start2    = (r_state == dcr_pkg::S_PASS1) && pass_end;
        o_ctl.done      = (r_state == dcr_pkg::S_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcr_pkg::S_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_task  <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= rd_en;
            if (accept || (r_state == dcr_pkg::S_PASS1 && pass_end)) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (accept) begin
                r_task <= r_count;
                if (i_last) begin
                    r_count <= '0;
                end else if (!tbl_full) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[dcr_pkg::IDX_W-1:0];
    end

endmodule

FILE: hdl/dcr_dpath.sv
// Datapath: holds the direct mask, ORs in closure rows read from the store
// and forms the reduction and status of the result. Depends on dcr_pkg.
module dcr_dpath (
    input  logic                       i_clk,
    input  dcr_pkg::t_ctl              i_ctl,
    input  logic [dcr_pkg::MASK_W-1:0] i_dep,
    input  logic                       i_last,
    input  logic [dcr_pkg::MASK_W-1:0] i_rd_data,
    output logic [dcr_pkg::MASK_W-1:0] o_full,
    output dcr_pkg::t_res              o_res
);

    logic [dcr_pkg::MASK_W-1:0] r_sel;
    logic [dcr_pkg::MASK_W-1:0] r_full;
    logic [dcr_pkg::MASK_W-1:0] r_impl;
    logic [dcr_pkg::IDX_W-1:0]  r_tno;
    logic                       r_fwd;
    logic                       r_tbl;
    logic                       r_last;

    logic [dcr_pkg::MASK_W-1:0] below;
    logic [dcr_pkg::MASK_W-1:0] direct;
    logic                       hit;

    // Bits at the task's own index and above are forward references.
    assign below  = (dcr_pkg::MASK_W'(1) << i_ctl.task_no) - dcr_pkg::MASK_W'(1);
    assign direct = i_dep & below;
    assign hit    = i_ctl.rd_v && r_sel[i_ctl.rd_idx];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sel  <= direct;
            r_full <= i_ctl.tbl_full ? '0 : direct;
            r_impl <= '0;
            r_fwd  <= |(i_dep & ~below);
            r_tbl  <= i_ctl.tbl_full;
            r_last <= i_last;
            r_tno  <= i_ctl.tbl_full ? '0 : i_ctl.task_no[dcr_pkg::IDX_W-1:0];
        end else begin
            if (i_ctl.start2) begin
                r_sel <= r_full;
            end
            if (hit && i_ctl.pass2) begin
                r_impl <= r_impl | i_rd_data;
            end
            if (hit && !i_ctl.pass2) begin
                r_full <= r_full | i_rd_data;
            end
        end
    end

    assign o_full        = r_full;
    assign o_res.full    = r_full;
    assign o_res.reduced = r_full & ~r_impl;
    assign o_res.tno     = r_tno;
    assign o_res.last    = r_last;
    assign o_res.status  = r_tbl ? dcr_pkg::ST_FULL :
                           (r_fwd ? dcr_pkg::ST_FWD : dcr_pkg::ST_OK);

endmodule

FILE: hdl/dag_closure_and_reduction.sv
// Top level of the DAG transitive closure and reduction block.
// Depends on dcr_pkg, dcr_ram, dcr_ctrl, dcr_dpath and assert_macros.svh.
//
// Usage: one item per task arrives on the slave stream, in task order; tdata
// is the direct dependency mask and tlast marks the final task of a graph,
// after which numbering restarts at task 0. For every item exactly one
// result leaves on the master stream: task index, closure, reduction and
// status, with tlast echoing the input flag.
// The two passes of an item for task t each read t closure rows from the
// store, one row per cycle through its single read port; task 0 reads none,
// and a table-full item skips both passes.
// The next item is accepted as soon as the sequencer has handed its result
// to the output register, even while that result still waits for tready.
// A stalled receiver holds the result in place; the sequencer then waits
// with the next finished result and the slave side sees tready low.
// Reset clears the task count and the handshakes. The store is not cleared:
// a task only reads rows below its own index, which the current graph has
// already written, so no clearing pass is needed and items are taken at once.
`include "assert_macros.svh"

module dag_closure_and_reduction #(
    parameter int MAX_TASKS = dcr_pkg::MAX_TASKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,  // [63:0] dep_mask
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [5:0] task_index, [69:6] full_mask, [133:70] reduced_mask, [135:134] status
    output logic [135:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast
);

    localparam int AW = $clog2(MAX_TASKS);

    dcr_pkg::t_ctl ctl;
    dcr_pkg::t_res res;
    dcr_pkg::t_res r_out;
    logic          r_out_v;

    logic                       out_free;
    logic                       rd_en;
    logic                       wr_en;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [dcr_pkg::MASK_W-1:0] rd_data;
    logic [dcr_pkg::MASK_W-1:0] full;

    assign out_free = !r_out_v || i_m_axis_tready;

    dcr_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_last     (i_s_axis_tlast),
        .i_out_free (out_free),
        .o_ready    (o_s_axis_tready),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_ctl      (ctl)
    );

    dcr_ram #(
        .WIDTH (dcr_pkg::MASK_W),
        .DEPTH (MAX_TASKS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (full),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    dcr_dpath u_dpath (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_dep     (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_rd_data (rd_data),
        .o_full    (full),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ctl.done) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.done) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out.status, r_out.reduced, r_out.full, r_out.tno};
    assign o_m_axis_tlast  = r_out.last;

    `DCR_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready, "input accepted while an item is still in work")
    `DCR_ASSERT(a_no_port_clash, i_clk, i_rst_n, !(rd_en && wr_en), "row write overlaps a row read")
    `DCR_ASSERT(a_reduced_in_full, i_clk, i_rst_n, r_out_v |-> ((r_out.reduced & ~r_out.full) == '0), "reduction holds a bit outside the closure")
    `DCR_ASSERT(a_full_result_empty, i_clk, i_rst_n, (r_out_v && r_out.status == dcr_pkg::ST_FULL) |-> (r_out.full == '0 && r_out.tno == '0), "ignored item carries data")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for dag_closure_and_reduction: streams task graphs and
// checks every closure and reduction against a cycle-free model kept here.
// Depends on dcr_pkg and the block's RTL only.
module tb_top;

    localparam int TBL_DEPTH   = dcr_pkg::MAX_TASKS_DEF;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 200;
    localparam int RUN_LIMIT   = 2_800_000;

    typedef struct {
        logic [dcr_pkg::IDX_W-1:0]  idx;
        logic [dcr_pkg::MASK_W-1:0] full;
        logic [dcr_pkg::MASK_W-1:0] reduced;
        dcr_pkg::t_status           status;
        logic                       last;
    } t_task_result;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tlast;

    // Model state: one closure row per task and the index of the next task.
    logic [dcr_pkg::MASK_W-1:0] closure_model [TBL_DEPTH];
    logic [dcr_pkg::CNT_W-1:0]  next_task;

    t_task_result pending_results[$];
    int  n_fail = 0;
    int  items_sent = 0;
    bit  src_idle_en = 1'b1;
    bit  sink_idle_en = 1'b1;
    bit  sink_hold_req = 1'b0;

    dag_closure_and_reduction #(
        .MAX_TASKS(TBL_DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [dcr_pkg::MASK_W-1:0] rows_union(
        logic [dcr_pkg::MASK_W-1:0] sel);
        logic [dcr_pkg::MASK_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (sel[i]) acc |= closure_model[i];
        end
        return acc;
    endfunction

    function automatic t_task_result predict_closure(logic [dcr_pkg::MASK_W-1:0] dep,
                                                     logic last);
        t_task_result r;
        logic [dcr_pkg::MASK_W-1:0] below;
        logic [dcr_pkg::MASK_W-1:0] direct;
        int t;
        t = next_task;
        if (t >= TBL_DEPTH) begin
            r.idx     = '0;
            r.full    = '0;
            r.reduced = '0;
            r.status  = dcr_pkg::ST_FULL;
        end else begin
            below     = (t == 0) ? '0 : ((64'd1 << t) - 64'd1);
            direct    = dep & below;
            r.idx     = t[dcr_pkg::IDX_W-1:0];
            r.full    = direct | rows_union(direct);
            // A member's own row only holds lower tasks, so it never hides itself.
            r.reduced = r.full & ~rows_union(r.full);
            r.status  = ((dep & ~below) != '0) ? dcr_pkg::ST_FWD : dcr_pkg::ST_OK;
            closure_model[t] = r.full;
            next_task = dcr_pkg::CNT_W'(t + 1);
        end
        r.last = last;
        if (last) next_task = '0;
        return r;
    endfunction

    // Dependency mask for the task at position p of a graph: mostly sparse
    // legal masks, with some dense, single-bit, empty and forward-reference ones.
    function automatic logic [dcr_pkg::MASK_W-1:0] gen_dep(int p);
        logic [dcr_pkg::MASK_W-1:0] below;
        logic [dcr_pkg::MASK_W-1:0] m;
        int kind;
        int hi;
        below = (p >= 64) ? '1 : ((64'd1 << p) - 64'd1);
        hi    = (p > 64) ? 63 : p - 1;
        kind  = $urandom_range(0, 19);
        m     = '0;
        if (kind < 11) begin
            for (int i = 0; i < 64; i++) begin
                if (i < p && $urandom_range(0, 3) == 0) m[i] = 1'b1;
            end
        end else if (kind < 14) begin
            m = {$urandom, $urandom} & below;
        end else if (kind < 17) begin
            m = {$urandom, $urandom};
        end else if (kind < 19 && p > 0) begin
            m = 64'd1 << $urandom_range(0, hi);
        end
        return m;
    endfunction

    task automatic send_item(input logic [63:0] dep, input logic last);
        t_task_result r;
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dep;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        r = predict_closure(dep, last);
        pending_results = {pending_results, r};
        items_sent++;
    endtask

    task automatic send_graph(input int len);
        for (int p = 0; p < len; p++) begin
            send_item(gen_dep(p), p == len - 1);
        end
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);  // task 0 can name nothing
        send_item(64'h1, 1'b0);
        send_item(64'h3, 1'b0);                    // bit 0 is implied through task 1
        send_item(64'h0, 1'b0);
        send_item(64'h6, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'h8000_0000_0000_0000, 1'b0);
        send_item(64'h28, 1'b1);
        send_item(64'h0, 1'b1);                    // one-task graph
        send_item(64'h1, 1'b0);                    // self reference
        send_item(64'h2, 1'b1);
        send_item(64'h5555_5555_5555_5555, 1'b0);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_item(64'h7, 1'b1);
    endtask

    // Fill the whole table, then two ignored items; the end flag on the
    // second one must restart numbering.
    task automatic test_table_full();
        for (int p = 0; p < TBL_DEPTH; p++) begin
            send_item((p % 3 == 0 && p > 0) ? (64'd1 << (p - 1)) : gen_dep(p), 1'b0);
        end
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'h0, 1'b1);
        send_item(64'h0, 1'b0);
        send_item(64'h1, 1'b1);
    endtask

    task automatic test_backpressure();
        sink_hold_req = 1'b1;
        for (int p = 0; p < 20; p++) begin
            send_item(gen_dep(p), p == 19);
        end
    endtask

    task automatic test_drain_pause();
        send_graph(6);
        s_tvalid <= 1'b0;
        wait_for_results();
        send_graph(5);
    endtask

    task automatic test_random_graphs();
        int len;
        int stop_at;
        stop_at = items_sent + 300;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 39))
                0:       len = TBL_DEPTH + $urandom_range(1, 3);
                1, 2, 3: len = $urandom_range(13, TBL_DEPTH);
                default: len = $urandom_range(1, 12);
            endcase
            send_graph(len);
        end
    endtask

    task automatic test_steady_tail();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int g = 0; g < 5; g++) begin
            send_graph($urandom_range(4, 12));
        end
        s_tvalid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
                sink_hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        t_task_result e;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation: tdata %h", m_tdata);
                n_fail++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[5:0] !== e.idx) begin
                    $error("task_index mismatch: expected %0d, actual %0d", e.idx, m_tdata[5:0]);
                    n_fail++;
                end
                if (m_tdata[69:6] !== e.full) begin
                    $error("full_mask mismatch: expected %h, actual %h", e.full, m_tdata[69:6]);
                    n_fail++;
                end
                if (m_tdata[133:70] !== e.reduced) begin
                    $error("reduced_mask mismatch: expected %h, actual %h",
                           e.reduced, m_tdata[133:70]);
                    n_fail++;
                end
                if (m_tdata[135:134] !== e.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           e.status, m_tdata[135:134]);
                    n_fail++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_task_res mismatch: expected %0d, actual %0d", e.last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++) closure_model[i] = '0;
        next_task = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_drain_pause();
        test_random_graphs();
        test_steady_tail();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
